// ----- hdl/rfpb_pkg.sv -----
// ----------------------------------------------------------------------------
// rfpb_pkg
// Types and constants shared by the RTCP feedback packet builder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rfpb_pkg;

    localparam int APB_AW = 3;

    localparam logic [7:0]  HDR_PLI  = 8'h81;
    localparam logic [7:0]  HDR_FIR  = 8'h84;
    localparam logic [7:0]  HDR_REMB = 8'h8F;
    localparam logic [7:0]  PT_PSFB  = 8'd206;
    localparam logic [31:0] REMB_TAG = 32'h52454D42;

    localparam logic [15:0] LEN_PLI = 16'd2;
    localparam logic [15:0] LEN_FIR = 16'd4;
    localparam logic [15:0] LEN_REMB_BASE = 16'd4;

    localparam logic [11:0] BYTES_PLI = 12'd12;
    localparam logic [11:0] BYTES_FIR = 12'd20;
    localparam logic [11:0] BYTES_REMB_BASE = 12'd20;

    localparam logic [10:0] MAX_BYTES_RESET = 11'd1040;

    localparam logic [5:0] MANT_MSB = 6'd17;

    localparam logic [1:0] MODE_PLI  = 2'd0;
    localparam logic [1:0] MODE_FIR  = 2'd1;
    localparam logic [1:0] MODE_REMB = 2'd2;

    localparam logic [APB_AW-1:0] ADDR_SENDER_SSRC = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_MAX_BYTES   = 3'd4;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        K_PLI,
        K_FIR,
        K_REMB,
        K_ENTRY,
        K_ERROR
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  media;
        logic         last;
        logic [7:0]   seq;
        logic [7:0]   count;
        logic [23:0]  code;
    } t_desc;

endpackage

`default_nettype wire

// ----- hdl/rfpb_front.sv -----
// ----------------------------------------------------------------------------
// rfpb_front
// Accepts items, tracks list and FIR state, classifies each item into a
// packet descriptor and finishes the bitrate code before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfpb_front #(
    parameter int MAX_LIST_ENTRIES = 255
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_mode,
    input  wire logic [31:0]      i_media_ssrc,
    input  wire logic [63:0]      i_bitrate,
    input  wire logic [7:0]       i_ssrc_count,
    input  wire logic [10:0]      i_max_bytes,
    output logic                  o_push_valid,
    input  wire logic             i_push_ready,
    output rfpb_pkg::t_desc       o_push_desc
);

    logic                  r_s1_valid;
    rfpb_pkg::t_desc       r_s1_desc;
    logic [63:0]           r_bps;
    logic [3:0]            r_nz;
    logic [3:0][3:0]       r_lpos;
    logic [7:0]            r_seq;
    logic [7:0]            r_entries;
    logic                  r_rej;

    logic [7:0]            n_seq;
    logic [7:0]            n_entries;
    logic                  n_rej;

    logic                  accept;
    logic                  c_push;
    rfpb_pkg::t_desc       c_desc;
    logic [11:0]           c_bytes;
    logic [11:0]           c_max;
    logic [3:0]            c_nz;
    logic [3:0][3:0]       c_lpos;

    logic [1:0]            sel;
    logic [5:0]            msb;
    logic [5:0]            sh;
    logic [63:0]           shifted;
    logic [23:0]           code;

    assign o_in_ready = !r_s1_valid || i_push_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign c_bytes    = rfpb_pkg::BYTES_REMB_BASE + {2'b00, i_ssrc_count, 2'b00};
    assign c_max      = {1'b0, i_max_bytes};

    always_comb begin
        c_push    = 1'b0;
        n_seq     = r_seq;
        n_entries = r_entries;
        n_rej     = r_rej;
        c_desc.kind  = rfpb_pkg::K_ERROR;
        c_desc.media = i_media_ssrc;
        c_desc.last  = 1'b1;
        c_desc.seq   = r_seq;
        c_desc.count = i_ssrc_count;
        c_desc.code  = 24'd0;
        if (r_entries != 8'd0) begin
            n_entries = r_entries - 8'd1;
            if (r_rej) begin
                if (n_entries == 8'd0) begin
                    n_rej = 1'b0;
                end
            end else begin
                c_push      = 1'b1;
                c_desc.kind = rfpb_pkg::K_ENTRY;
                c_desc.last = (r_entries == 8'd1);
            end
        end else begin
            case (i_mode)
                rfpb_pkg::MODE_PLI: begin
                    c_push = 1'b1;
                    if (c_max >= rfpb_pkg::BYTES_PLI) begin
                        c_desc.kind = rfpb_pkg::K_PLI;
                    end
                end
                rfpb_pkg::MODE_FIR: begin
                    c_push = 1'b1;
                    if (c_max >= rfpb_pkg::BYTES_FIR) begin
                        c_desc.kind = rfpb_pkg::K_FIR;
                        n_seq       = r_seq + 8'd1;
                    end
                end
                rfpb_pkg::MODE_REMB: begin
                    c_push = 1'b1;
                    if (i_ssrc_count != 8'd0) begin
                        n_entries = i_ssrc_count - 8'd1;
                        if (c_bytes > c_max || i_ssrc_count > 8'(MAX_LIST_ENTRIES)) begin
                            n_rej = (n_entries != 8'd0);
                        end else begin
                            n_rej       = 1'b0;
                            c_desc.kind = rfpb_pkg::K_REMB;
                            c_desc.last = (i_ssrc_count == 8'd1);
                        end
                    end
                end
                default: begin
                    c_push = 1'b0;
                end
            endcase
        end
    end

    // leading-one position within each 16-bit slice
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            c_nz[j]   = |i_bitrate[16*j +: 16];
            c_lpos[j] = 4'd0;
            for (int i = 0; i < 16; i++) begin
                if (i_bitrate[16*j + i]) begin
                    c_lpos[j] = 4'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_seq      <= 8'd0;
            r_entries  <= 8'd0;
            r_rej      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= accept && c_push;
            end
            if (accept) begin
                r_seq     <= n_seq;
                r_entries <= n_entries;
                r_rej     <= n_rej;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_desc <= c_desc;
            r_bps     <= i_bitrate;
            r_nz      <= c_nz;
            r_lpos    <= c_lpos;
        end
    end

    // finish normalization: mantissa keeps bits msb..msb-17
    always_comb begin
        sel = 2'd0;
        for (int j = 0; j < 4; j++) begin
            if (r_nz[j]) begin
                sel = 2'(j);
            end
        end
        msb     = {sel, r_lpos[sel]};
        sh      = msb - rfpb_pkg::MANT_MSB;
        shifted = r_bps >> sh;
        if ((|r_nz) && (msb > rfpb_pkg::MANT_MSB)) begin
            code = {sh, shifted[17:0]};
        end else begin
            code = {6'd0, r_bps[17:0]};
        end
    end

    always_comb begin
        o_push_desc      = r_s1_desc;
        o_push_desc.code = code;
    end

    assign o_push_valid = r_s1_valid;

endmodule

`default_nettype wire

// ----- hdl/rfpb_queue.sv -----
// ----------------------------------------------------------------------------
// rfpb_queue
// Short descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rfpb_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  rfpb_pkg::t_desc       i_push_desc,
    output logic                  o_pop_valid,
    input  wire logic             i_pop,
    output rfpb_pkg::t_desc       o_pop_desc
);

    rfpb_pkg::t_desc                r_mem [rfpb_pkg::Q_DEPTH];
    logic [rfpb_pkg::Q_AW-1:0]      r_wr_ptr;
    logic [rfpb_pkg::Q_AW-1:0]      r_rd_ptr;
    logic [rfpb_pkg::Q_AW:0]        r_cnt;
    logic                           push;
    logic                           pop;

    assign o_push_ready = (r_cnt != (rfpb_pkg::Q_AW+1)'(rfpb_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_desc   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rfpb_back.sv -----
// ----------------------------------------------------------------------------
// rfpb_back
// Walks one descriptor at a time and emits its packet words, one word per
// cycle while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rfpb_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_pop_valid,
    output logic                  o_pop,
    input  rfpb_pkg::t_desc       i_pop_desc,
    input  wire logic [31:0]      i_sender_ssrc,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [31:0]           o_packet_word,
    output logic                  o_last_word,
    output logic                  o_status
);

    logic                  r_act;
    rfpb_pkg::t_desc       r_desc;
    logic [2:0]            r_idx;
    logic                  r_ovalid;
    logic [31:0]           r_word;
    logic                  r_last;
    logic                  r_status;

    logic                  out_load;
    logic                  emit;
    logic                  fin;
    logic [2:0]            last_idx;
    logic [31:0]           word;
    logic                  status;
    logic [15:0]           remb_len;

    assign out_load = !r_ovalid || i_out_ready;
    assign emit     = r_act && out_load;
    assign fin      = emit && (r_idx == last_idx);
    assign o_pop    = i_pop_valid && (!r_act || fin);
    assign remb_len = rfpb_pkg::LEN_REMB_BASE + {8'd0, r_desc.count};

    always_comb begin
        word   = 32'd0;
        status = 1'b0;
        case (r_desc.kind)
            rfpb_pkg::K_PLI: begin
                last_idx = 3'd2;
                case (r_idx)
                    3'd0:    word = {rfpb_pkg::HDR_PLI, rfpb_pkg::PT_PSFB, rfpb_pkg::LEN_PLI};
                    3'd1:    word = i_sender_ssrc;
                    default: word = r_desc.media;
                endcase
            end
            rfpb_pkg::K_FIR: begin
                last_idx = 3'd4;
                case (r_idx)
                    3'd0:    word = {rfpb_pkg::HDR_FIR, rfpb_pkg::PT_PSFB, rfpb_pkg::LEN_FIR};
                    3'd1:    word = i_sender_ssrc;
                    3'd2:    word = r_desc.media;
                    3'd3:    word = r_desc.media;
                    default: word = {r_desc.seq, 24'd0};
                endcase
            end
            rfpb_pkg::K_REMB: begin
                last_idx = 3'd5;
                case (r_idx)
                    3'd0:    word = {rfpb_pkg::HDR_REMB, rfpb_pkg::PT_PSFB, remb_len};
                    3'd1:    word = i_sender_ssrc;
                    3'd2:    word = 32'd0;
                    3'd3:    word = rfpb_pkg::REMB_TAG;
                    3'd4:    word = {r_desc.count, r_desc.code};
                    default: word = r_desc.media;
                endcase
            end
            rfpb_pkg::K_ENTRY: begin
                last_idx = 3'd0;
                word     = r_desc.media;
            end
            default: begin
                last_idx = 3'd0;
                status   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (fin) begin
                r_act <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (out_load) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_pop_desc;
            r_idx  <= 3'd0;
        end else if (emit) begin
            r_idx  <= r_idx + 3'd1;
        end
        if (emit) begin
            r_word   <= word;
            r_last   <= (r_idx == last_idx) && (status || r_desc.kind == rfpb_pkg::K_PLI ||
                        r_desc.kind == rfpb_pkg::K_FIR || r_desc.last);
            r_status <= status;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_packet_word = r_word;
    assign o_last_word   = r_last;
    assign o_status      = r_status;

endmodule

`default_nettype wire

// ----- hdl/rtcp_feedback_packet_builder.sv -----
// ----------------------------------------------------------------------------
// rtcp_feedback_packet_builder
// Builds RTCP payload-specific feedback packets (PLI, FIR, REMB) as 32-bit
// big-endian words.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid/o_in_ready carry one item per beat (mode, media
// SSRC, bitrate, entry count). Output channel: o_out_valid/i_out_ready carry
// one packet word per beat, with o_last_word closing a packet and o_status
// flagging an error beat (zero count, too many list entries or a packet
// over capacity). Registers on the APB port: address 0 sender SSRC,
// address 4 capacity in bytes; write them only while the block is idle.
// An item's first word passes the front stage register, the descriptor
// queue, the back descriptor register and the output word register.
// Throughput: one output word per cycle while the receiver is ready; an
// item yields 1 to 6 words (PLI 3, FIR 5, REMB header 6, list entry or
// error 1); swallowed entries and unused modes take one input beat and
// produce nothing. The single word-wide output register sets that rate.
// A four-entry descriptor queue lets input beats continue while words
// drain; when the receiver stalls, the output word holds and the queue
// fills, then o_in_ready drops. Reset clears the queue, the open list, the
// FIR sequence number and both registers (capacity back to 1040 bytes).
`default_nettype none

module rtcp_feedback_packet_builder #(
    parameter int MAX_LIST_ENTRIES = 255
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_mode,
    input  wire logic [31:0]                   i_media_ssrc,
    input  wire logic [63:0]                   i_bitrate,
    input  wire logic [7:0]                    i_ssrc_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [31:0]                        o_packet_word,
    output logic                               o_last_word,
    output logic                               o_status,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rfpb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [31:0]        r_sender_ssrc;
    logic [10:0]        r_max_bytes;
    logic               cfg_wr;

    logic               push_valid;
    logic               push_ready;
    rfpb_pkg::t_desc    push_desc;
    logic               pop_valid;
    logic               pop;
    rfpb_pkg::t_desc    pop_desc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == rfpb_pkg::ADDR_MAX_BYTES[2]) ? {21'd0, r_max_bytes}
                                                            : r_sender_ssrc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sender_ssrc <= 32'd0;
            r_max_bytes   <= rfpb_pkg::MAX_BYTES_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == rfpb_pkg::ADDR_SENDER_SSRC[2]) begin
                r_sender_ssrc <= pwdata;
            end else begin
                r_max_bytes   <= pwdata[10:0];
            end
        end
    end

    rfpb_front #(
        .MAX_LIST_ENTRIES (MAX_LIST_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_media_ssrc (i_media_ssrc),
        .i_bitrate    (i_bitrate),
        .i_ssrc_count (i_ssrc_count),
        .i_max_bytes  (r_max_bytes),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_desc  (push_desc)
    );

    rfpb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_desc  (push_desc),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_desc   (pop_desc)
    );

    rfpb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop         (pop),
        .i_pop_desc    (pop_desc),
        .i_sender_ssrc (r_sender_ssrc),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packet_word (o_packet_word),
        .o_last_word   (o_last_word),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

// ----- hdl/rfpb_checker.sv -----
// ----------------------------------------------------------------------------
// rfpb_checker
// Port-level checks for the RTCP feedback packet builder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rfpb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_packet_word,
    input wire logic        o_last_word,
    input wire logic        o_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_packet_word) &&
        $stable(o_last_word) && $stable(o_status))
        else $error("output beat changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_last_word)
        else $error("error beat without last flag");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_packet_word == 32'd0)
        else $error("error beat with nonzero word");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind rtcp_feedback_packet_builder rfpb_checker u_rfpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_packet_word (o_packet_word),
    .o_last_word   (o_last_word),
    .o_status      (o_status)
);

`default_nettype wire
